>>> hdl/frs_pkg.sv
`default_nettype none
package frs_pkg;

	localparam int DEF_QUEUE_DEPTH = 64;

	localparam int MODE_W = 3;
	localparam int TIME_W = 64;
	localparam int VR_W = 64;
	localparam int TID_W = 16;
	localparam int NICE_W = 6;
	localparam int STAT_W = 2;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int WEIGHT_W = 17;
	localparam int CHG_SHIFT = 10;
	localparam int DVD_W = TIME_W + CHG_SHIFT;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);
	localparam int ENT_W = VR_W + TID_W + NICE_W;
	localparam int NICE_OFFSET = 20;
	localparam int NICE_LEVELS = 40;

	localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WAKE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_YIELD = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PICK = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TICK = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_BONUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLICE = 2'd2;

	localparam logic [CFG_W-1:0] RST_SLEEP_BONUS = 32'd20000000;
	localparam logic [CFG_W-1:0] RST_PERIOD = 32'd4000000;
	localparam logic [CFG_W-1:0] RST_MIN_SLICE = 32'd1000;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ROM [NICE_LEVELS] = '{
		17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291,
		17'd29154, 17'd23254, 17'd18705, 17'd14949, 17'd11916,
		17'd9548, 17'd7620, 17'd6100, 17'd4904, 17'd3906,
		17'd3121, 17'd2501, 17'd1991, 17'd1586, 17'd1277,
		17'd1024, 17'd820, 17'd655, 17'd526, 17'd423,
		17'd335, 17'd272, 17'd215, 17'd172, 17'd137,
		17'd110, 17'd87, 17'd70, 17'd56, 17'd45,
		17'd36, 17'd29, 17'd23, 17'd18, 17'd15
	};

	function automatic logic [WEIGHT_W-1:0] weight_of(input logic [NICE_W-1:0] nice);
		logic signed [NICE_W:0] v;
		v = $signed({nice[NICE_W-1], nice}) + 7'(NICE_OFFSET);
		if (v < 0) begin
			return WEIGHT_ROM[0];
		end else if (v > 7'(NICE_LEVELS - 1)) begin
			return WEIGHT_ROM[NICE_LEVELS-1];
		end else begin
			return WEIGHT_ROM[v[NICE_W-1:0]];
		end
	endfunction

	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_CHG_GO, ST_CHG_WAIT, ST_CHG_APPLY, ST_HEAD_RD, ST_FLOOR,
		ST_DISPATCH, ST_INS_CHK, ST_INS_RD, ST_INS_STEP, ST_INS_PUT, ST_INS_FIN,
		ST_PICK_RD0, ST_PICK_TAKE, ST_PICK_CHK, ST_PICK_RD, ST_PICK_MV, ST_PICK_FIN,
		ST_TICK_M1, ST_TICK_M2, ST_TICK_DIV, ST_TICK_WAIT, ST_TICK_CMP, ST_DONE
	} fsm_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_CHG_DIV, OP_CHG_APPLY, OP_HEAD_RD, OP_FLOOR, OP_KEY,
		OP_EMPTY, OP_BLOCK, OP_INS_RD, OP_INS_STEP, OP_INS_PUT, OP_INS_FIN,
		OP_PICK_RD0, OP_PICK_TAKE, OP_PICK_RD, OP_PICK_MV, OP_PICK_FIN,
		OP_TICK_M1, OP_TICK_M2, OP_TICK_DIV, OP_TICK_CMP, OP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic run_valid;
		logic empty;
		logic full;
		logic idx_zero;
		logic idx_at_cnt;
		logic ent_moves;
		logic div_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> hdl/fair_share_run_queue_unit.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    mode, now, thread_id, thread_nice, thread_vruntime
// out       output     out_valid / out_ready  want_resched, status, out_thread_id, out_vruntime
// cfg       input      cfg_we                 cfg_idx, cfg_data
// one event at a time; a charge runs through the 74-step shift-subtract divider
// tick adds a second division; insert and pick walk the queue RAM,
// checking, reading and writing back each entry moved
// reset empties the queue at once through the ready count, no clearing pass
// a finished result waits in the output register while the next event is taken
`default_nettype none
module fair_share_run_queue_unit #(
	parameter int QUEUE_DEPTH = frs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [frs_pkg::MODE_W-1:0]        mode,
	input  logic [frs_pkg::TIME_W-1:0]        now,
	input  logic [frs_pkg::TID_W-1:0]         thread_id,
	input  logic signed [frs_pkg::NICE_W-1:0] thread_nice,
	input  logic [frs_pkg::VR_W-1:0]          thread_vruntime,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              want_resched,
	output logic [frs_pkg::STAT_W-1:0]        status,
	output logic [frs_pkg::TID_W-1:0]         out_thread_id,
	output logic [frs_pkg::VR_W-1:0]          out_vruntime,
	input  logic                              cfg_we,
	input  logic [frs_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [frs_pkg::CFG_W-1:0]         cfg_data
);
	import frs_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	frs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	frs_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.mode(mode),
		.now(now),
		.thread_id(thread_id),
		.thread_nice(thread_nice),
		.thread_vruntime(thread_vruntime),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.want_resched(want_resched),
		.status(status),
		.out_thread_id(out_thread_id),
		.out_vruntime(out_vruntime)
	);
endmodule
`default_nettype wire

>>> hdl/frs_ram.sv
`default_nettype none
module frs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> hdl/frs_div.sv
`default_nettype none
module frs_div #(
	parameter int DSR_W = 25
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [frs_pkg::DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0]          divisor,
	output logic                      busy,
	output logic [frs_pkg::DVD_W-1:0] quotient
);
	import frs_pkg::*;

	logic [DVD_W-1:0]     quo_q;
	logic [DSR_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DSR_W:0]       trial;
	logic [DSR_W:0]       diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign fits = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> hdl/frs_dp.sv
`default_nettype none
module frs_dp #(
	parameter int QUEUE_DEPTH = frs_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frs_pkg::dp_cmd_t              cmd,
	output frs_pkg::dp_sts_t              sts,
	input  logic [frs_pkg::MODE_W-1:0]    mode,
	input  logic [frs_pkg::TIME_W-1:0]    now,
	input  logic [frs_pkg::TID_W-1:0]     thread_id,
	input  logic signed [frs_pkg::NICE_W-1:0] thread_nice,
	input  logic [frs_pkg::VR_W-1:0]      thread_vruntime,
	input  logic                          cfg_we,
	input  logic [frs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [frs_pkg::CFG_W-1:0]     cfg_data,
	output logic                          want_resched,
	output logic [frs_pkg::STAT_W-1:0]    status,
	output logic [frs_pkg::TID_W-1:0]     out_thread_id,
	output logic [frs_pkg::VR_W-1:0]      out_vruntime
);
	import frs_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int LOAD_W = WEIGHT_W + CNT_W;
	localparam int DSR_W = LOAD_W + 1;
	localparam int N_W = $clog2(QUEUE_DEPTH + 2);
	localparam int P1_W = CFG_W + N_W;
	localparam int P2_W = P1_W + WEIGHT_W;

	logic [CNT_W-1:0]  count_q;
	logic [LOAD_W-1:0] load_q;
	logic [VR_W-1:0]   floor_q;
	logic              run_valid_q;
	logic [TID_W-1:0]  run_tid_q;
	logic [NICE_W-1:0] run_nice_q;
	logic [VR_W-1:0]   run_vr_q;
	logic [TIME_W-1:0] run_last_q;
	logic [TIME_W-1:0] run_start_q;
	logic [CFG_W-1:0]  sleep_q;
	logic [CFG_W-1:0]  period_q;
	logic [CFG_W-1:0]  minsl_q;

	logic [MODE_W-1:0] mode_q;
	logic [TIME_W-1:0] now_q;
	logic [TID_W-1:0]  tid_q;
	logic [NICE_W-1:0] nice_q;
	logic [VR_W-1:0]   tvr_q;
	logic [VR_W-1:0]   key_vr_q;
	logic [TID_W-1:0]  key_tid_q;
	logic [NICE_W-1:0] key_nice_q;
	logic [CNT_W-1:0]  idx_q;
	logic [P1_W-1:0]   prod_s1;
	logic [P2_W-1:0]   prod_s2;
	logic              want_q;
	logic [STAT_W-1:0] stat_q;
	logic [TID_W-1:0]  otid_q;
	logic [VR_W-1:0]   ovr_q;
	logic              want_out_q;
	logic [STAT_W-1:0] stat_out_q;
	logic [TID_W-1:0]  otid_out_q;
	logic [VR_W-1:0]   ovr_out_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;
	logic [VR_W-1:0]   ent_vr;
	logic [TID_W-1:0]  ent_tid;
	logic [NICE_W-1:0] ent_nice;
	logic [ENT_W-1:0]  key_ent;
	logic [CNT_W-1:0]  idx_m1;

	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [DSR_W-1:0]  div_dsr;
	logic              div_busy;
	logic [DVD_W-1:0]  div_quo;

	logic [TIME_W-1:0] delta;
	logic [TIME_W-1:0] ran;
	logic [WEIGHT_W-1:0] run_w;
	logic [VR_W-1:0]   inc;
	logic [VR_W:0]     vr_sum;
	logic [VR_W-1:0]   vr_charged;
	logic              floor_any;
	logic [VR_W-1:0]   floor_min;
	logic [VR_W-1:0]   wake_lim;
	logic [VR_W-1:0]   new_vr;
	logic [N_W-1:0]    n_val;
	logic [VR_W-1:0]   ideal;

	assign ent_vr = ram_rdata[ENT_W-1 -: VR_W];
	assign ent_tid = ram_rdata[NICE_W +: TID_W];
	assign ent_nice = ram_rdata[NICE_W-1:0];
	assign key_ent = {key_vr_q, key_tid_q, key_nice_q};
	assign idx_m1 = idx_q - 1'b1;

	assign delta = (now_q > run_last_q) ? now_q - run_last_q : '0;
	assign ran = (now_q > run_start_q) ? now_q - run_start_q : '0;
	assign run_w = weight_of(run_nice_q);
	assign inc = (|div_quo[DVD_W-1:VR_W]) ? '1 : div_quo[VR_W-1:0];
	assign vr_sum = {1'b0, run_vr_q} + {1'b0, inc};
	assign vr_charged = vr_sum[VR_W] ? '1 : vr_sum[VR_W-1:0];
	assign wake_lim = (floor_q > VR_W'(sleep_q)) ? floor_q - VR_W'(sleep_q) : '0;
	assign n_val = N_W'(count_q) + N_W'(1);
	assign ideal = (div_quo[VR_W-1:0] < VR_W'(minsl_q)) ? VR_W'(minsl_q) : div_quo[VR_W-1:0];

	always_comb begin
		floor_any = run_valid_q;
		floor_min = run_vr_q;
		if (count_q != '0 && (!run_valid_q || ent_vr < run_vr_q)) begin
			floor_any = 1'b1;
			floor_min = ent_vr;
		end
	end

	always_comb begin
		if (mode_q == MODE_YIELD) begin
			new_vr = run_vr_q;
		end else if (mode_q == MODE_WAKE) begin
			new_vr = (tvr_q < wake_lim) ? wake_lim : tvr_q;
		end else begin
			new_vr = floor_q;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd = {delta, CHG_SHIFT'(0)};
		div_dsr = DSR_W'(run_w);
		if (cmd.op == OP_CHG_DIV) begin
			div_start = 1'b1;
		end else if (cmd.op == OP_TICK_DIV) begin
			div_start = 1'b1;
			div_dvd = DVD_W'(prod_s2);
			div_dsr = DSR_W'(load_q) + DSR_W'(run_w);
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = key_ent;
		ram_re = 1'b0;
		ram_raddr = '0;
		unique case (cmd.op)
			OP_HEAD_RD, OP_PICK_RD0: begin
				ram_re = 1'b1;
			end
			OP_INS_RD: begin
				ram_re = 1'b1;
				ram_raddr = idx_m1[AW-1:0];
			end
			OP_INS_STEP: begin
				ram_we = 1'b1;
				ram_wdata = sts.ent_moves ? ram_rdata : key_ent;
			end
			OP_INS_PUT: begin
				ram_we = 1'b1;
			end
			OP_PICK_RD: begin
				ram_re = 1'b1;
				ram_raddr = idx_q[AW-1:0];
			end
			OP_PICK_MV: begin
				ram_we = 1'b1;
				ram_waddr = idx_m1[AW-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	frs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	frs_div #(
		.DSR_W(DSR_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dsr),
		.busy(div_busy),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			load_q <= '0;
			floor_q <= '0;
			run_valid_q <= 1'b0;
			run_tid_q <= '0;
			run_nice_q <= '0;
			run_vr_q <= '0;
			run_last_q <= '0;
			run_start_q <= '0;
			sleep_q <= RST_SLEEP_BONUS;
			period_q <= RST_PERIOD;
			minsl_q <= RST_MIN_SLICE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SLEEP_BONUS: sleep_q <= cfg_data;
					CFG_PERIOD: period_q <= cfg_data;
					CFG_MIN_SLICE: minsl_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (cmd.op)
				OP_CHG_APPLY: begin
					run_vr_q <= vr_charged;
					run_last_q <= now_q;
				end
				OP_FLOOR: begin
					if (floor_any && floor_min > floor_q) begin
						floor_q <= floor_min;
					end
				end
				OP_BLOCK: begin
					run_valid_q <= 1'b0;
				end
				OP_INS_FIN: begin
					count_q <= count_q + 1'b1;
					load_q <= load_q + LOAD_W'(weight_of(key_nice_q));
					if (mode_q == MODE_YIELD) begin
						run_valid_q <= 1'b0;
					end
				end
				OP_PICK_TAKE: begin
					run_valid_q <= 1'b1;
					run_vr_q <= ent_vr;
					run_tid_q <= ent_tid;
					run_nice_q <= ent_nice;
					run_start_q <= now_q;
					run_last_q <= now_q;
					load_q <= load_q - LOAD_W'(weight_of(ent_nice));
				end
				OP_PICK_FIN: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				mode_q <= mode;
				now_q <= now;
				tid_q <= thread_id;
				nice_q <= thread_nice;
				tvr_q <= thread_vruntime;
				want_q <= 1'b0;
				stat_q <= STAT_OK;
				otid_q <= '0;
				ovr_q <= '0;
			end
			OP_KEY: begin
				key_vr_q <= new_vr;
				key_tid_q <= (mode_q == MODE_YIELD) ? run_tid_q : tid_q;
				key_nice_q <= (mode_q == MODE_YIELD) ? run_nice_q : nice_q;
				idx_q <= count_q;
				stat_q <= sts.full ? STAT_FULL : STAT_OK;
			end
			OP_EMPTY: begin
				stat_q <= STAT_EMPTY;
			end
			OP_BLOCK: begin
				otid_q <= run_tid_q;
				ovr_q <= run_vr_q;
			end
			OP_INS_STEP: begin
				idx_q <= idx_m1;
			end
			OP_INS_FIN: begin
				if (mode_q != MODE_YIELD) begin
					want_q <= !run_valid_q || key_vr_q < run_vr_q;
				end
			end
			OP_PICK_TAKE: begin
				otid_q <= ent_tid;
				ovr_q <= ent_vr;
				idx_q <= CNT_W'(1);
			end
			OP_PICK_MV: begin
				idx_q <= idx_q + 1'b1;
			end
			OP_TICK_M1: begin
				prod_s1 <= P1_W'(period_q) * P1_W'(n_val);
			end
			OP_TICK_M2: begin
				prod_s2 <= P2_W'(prod_s1) * P2_W'(run_w);
			end
			OP_TICK_CMP: begin
				want_q <= ran >= ideal;
			end
			OP_PUSH: begin
				want_out_q <= want_q;
				stat_out_q <= stat_q;
				otid_out_q <= otid_q;
				ovr_out_q <= ovr_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sts.mode = mode_q;
		sts.run_valid = run_valid_q;
		sts.empty = count_q == '0;
		sts.full = count_q == CNT_W'(QUEUE_DEPTH);
		sts.idx_zero = idx_q == '0;
		sts.idx_at_cnt = idx_q == count_q;
		sts.ent_moves = ent_vr > key_vr_q || (ent_vr == key_vr_q && ent_tid > key_tid_q);
		sts.div_busy = div_busy;
	end

	assign want_resched = want_out_q;
	assign status = stat_out_q;
	assign out_thread_id = otid_out_q;
	assign out_vruntime = ovr_out_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("ready count beyond queue depth");
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INS_STEP || cmd.op == OP_INS_PUT) |-> (!sts.full && idx_q <= count_q))
		else $error("queue write outside occupied range");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_pick_grows_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PICK_TAKE |=> run_valid_q)
		else $error("pick left no running thread");
`endif
endmodule
`default_nettype wire

>>> hdl/frs_ctrl.sv
`default_nettype none
module frs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  frs_pkg::dp_sts_t sts,
	output frs_pkg::dp_cmd_t cmd
);
	import frs_pkg::*;

	fsm_t state_q;
	fsm_t state_nxt;
	logic out_valid_q;
	logic push;

	assign push = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_START;
			ST_START: begin
				case (sts.mode) inside
					MODE_ADD, MODE_WAKE, MODE_YIELD, MODE_TICK, MODE_BLOCK:
						state_nxt = sts.run_valid ? ST_CHG_GO : ST_HEAD_RD;
					MODE_PICK: state_nxt = ST_DISPATCH;
					default: state_nxt = ST_DONE;
				endcase
			end
			ST_CHG_GO: state_nxt = ST_CHG_WAIT;
			ST_CHG_WAIT: if (!sts.div_busy) state_nxt = ST_CHG_APPLY;
			ST_CHG_APPLY: state_nxt = ST_HEAD_RD;
			ST_HEAD_RD: state_nxt = ST_FLOOR;
			ST_FLOOR: state_nxt = ST_DISPATCH;
			ST_DISPATCH: begin
				case (sts.mode) inside
					MODE_ADD, MODE_WAKE: state_nxt = sts.full ? ST_DONE : ST_INS_CHK;
					MODE_YIELD:
						state_nxt = (sts.run_valid && !sts.full) ? ST_INS_CHK : ST_DONE;
					MODE_PICK: state_nxt = sts.empty ? ST_DONE : ST_PICK_RD0;
					MODE_TICK:
						state_nxt = (sts.run_valid && !sts.empty) ? ST_TICK_M1 : ST_DONE;
					default: state_nxt = ST_DONE;
				endcase
			end
			ST_INS_CHK: state_nxt = sts.idx_zero ? ST_INS_PUT : ST_INS_RD;
			ST_INS_RD: state_nxt = ST_INS_STEP;
			ST_INS_STEP: state_nxt = sts.ent_moves ? ST_INS_CHK : ST_INS_FIN;
			ST_INS_PUT: state_nxt = ST_INS_FIN;
			ST_INS_FIN: state_nxt = ST_DONE;
			ST_PICK_RD0: state_nxt = ST_PICK_TAKE;
			ST_PICK_TAKE: state_nxt = ST_PICK_CHK;
			ST_PICK_CHK: state_nxt = sts.idx_at_cnt ? ST_PICK_FIN : ST_PICK_RD;
			ST_PICK_RD: state_nxt = ST_PICK_MV;
			ST_PICK_MV: state_nxt = ST_PICK_CHK;
			ST_PICK_FIN: state_nxt = ST_DONE;
			ST_TICK_M1: state_nxt = ST_TICK_M2;
			ST_TICK_M2: state_nxt = ST_TICK_DIV;
			ST_TICK_DIV: state_nxt = ST_TICK_WAIT;
			ST_TICK_WAIT: if (!sts.div_busy) state_nxt = ST_TICK_CMP;
			ST_TICK_CMP: state_nxt = ST_DONE;
			ST_DONE: if (push) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: if (in_valid) cmd.op = OP_LATCH;
			ST_CHG_GO: cmd.op = OP_CHG_DIV;
			ST_CHG_APPLY: cmd.op = OP_CHG_APPLY;
			ST_HEAD_RD: cmd.op = OP_HEAD_RD;
			ST_FLOOR: cmd.op = OP_FLOOR;
			ST_DISPATCH: begin
				case (sts.mode) inside
					MODE_ADD, MODE_WAKE: cmd.op = OP_KEY;
					MODE_YIELD: if (sts.run_valid) cmd.op = OP_KEY;
					MODE_PICK: if (sts.empty) cmd.op = OP_EMPTY;
					MODE_BLOCK: if (sts.run_valid) cmd.op = OP_BLOCK;
					default: cmd.op = OP_NONE;
				endcase
			end
			ST_INS_RD: cmd.op = OP_INS_RD;
			ST_INS_STEP: cmd.op = OP_INS_STEP;
			ST_INS_PUT: cmd.op = OP_INS_PUT;
			ST_INS_FIN: cmd.op = OP_INS_FIN;
			ST_PICK_RD0: cmd.op = OP_PICK_RD0;
			ST_PICK_TAKE: cmd.op = OP_PICK_TAKE;
			ST_PICK_RD: cmd.op = OP_PICK_RD;
			ST_PICK_MV: cmd.op = OP_PICK_MV;
			ST_PICK_FIN: cmd.op = OP_PICK_FIN;
			ST_TICK_M1: cmd.op = OP_TICK_M1;
			ST_TICK_M2: cmd.op = OP_TICK_M2;
			ST_TICK_DIV: cmd.op = OP_TICK_DIV;
			ST_TICK_CMP: cmd.op = OP_TICK_CMP;
			ST_DONE: if (push) cmd.op = OP_PUSH;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

>>> tb/sv/fair_share_run_queue_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module fair_share_run_queue_unit_tb;
	import frs_pkg::*;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] now;
		logic [TID_W-1:0] tid;
		logic signed [NICE_W-1:0] nice;
		logic [VR_W-1:0] vr;
	} sched_event_t;

	typedef struct {
		logic want;
		logic [STAT_W-1:0] stat;
		logic [TID_W-1:0] tid;
		logic [VR_W-1:0] vr;
	} sched_result_t;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = '0;
	logic [TIME_W-1:0] now = '0;
	logic [TID_W-1:0] thread_id = '0;
	logic signed [NICE_W-1:0] thread_nice = '0;
	logic [VR_W-1:0] thread_vruntime = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic want_resched;
	logic [STAT_W-1:0] status;
	logic [TID_W-1:0] out_thread_id;
	logic [VR_W-1:0] out_vruntime;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	fair_share_run_queue_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .now(now), .thread_id(thread_id),
		.thread_nice(thread_nice), .thread_vruntime(thread_vruntime),
		.out_valid(out_valid), .out_ready(out_ready),
		.want_resched(want_resched), .status(status),
		.out_thread_id(out_thread_id), .out_vruntime(out_vruntime),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// predictor state
	logic [VR_W-1:0] rq_vr [DEPTH];
	logic [TID_W-1:0] rq_tid [DEPTH];
	logic [NICE_W-1:0] rq_nice [DEPTH];
	int rq_count = 0;
	logic [63:0] load_sum = 0;
	logic [VR_W-1:0] floor_vr = 0;
	logic run_valid = 0;
	logic [TID_W-1:0] run_tid = 0;
	logic [NICE_W-1:0] run_nice = 0;
	logic [VR_W-1:0] run_vr = 0;
	logic [TIME_W-1:0] run_last = 0;
	logic [TIME_W-1:0] run_start = 0;
	logic [31:0] bonus_reg = RST_SLEEP_BONUS;
	logic [31:0] period_reg = RST_PERIOD;
	logic [31:0] min_slice_reg = RST_MIN_SLICE;

	sched_event_t event_q [$];
	sched_result_t result_q [$];
	sched_event_t cur;
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;
	int long_hold = 0;
	int stall_left = 0;
	bit stall_mode = 0;
	logic [63:0] tnow = 0;

	initial forever #6 clk = ~clk;

	initial begin
		#(12 * 6000000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] nice_weight(input logic [NICE_W-1:0] n);
		int v;
		v = int'($signed(n)) + 20;
		if (v < 0) v = 0;
		if (v > 39) v = 39;
		return 64'(WEIGHT_ROM[v]);
	endfunction

	task automatic charge_running(input logic [63:0] t);
		logic [63:0] delta, w, q, r, inc, m;
		bit any;
		if (run_valid) begin
			delta = (t > run_last) ? t - run_last : 0;
			w = nice_weight(run_nice);
			q = delta / w;
			r = delta % w;
			run_last = t;
			if (q > (ALL_ONES >> 10)) inc = ALL_ONES;
			else inc = (q << 10) + ((r << 10) / w);
			if (run_vr > ALL_ONES - inc) run_vr = ALL_ONES;
			else run_vr = run_vr + inc;
		end
		any = 0;
		m = 0;
		if (run_valid) begin
			any = 1;
			m = run_vr;
		end
		if (rq_count > 0 && (!any || rq_vr[0] < m)) begin
			any = 1;
			m = rq_vr[0];
		end
		if (any && m > floor_vr) floor_vr = m;
	endtask

	function automatic bit ready_insert(input logic [63:0] vr, input logic [15:0] tid,
			input logic [NICE_W-1:0] n);
		int pos;
		if (rq_count >= DEPTH) return 0;
		pos = 0;
		while (pos < rq_count && (rq_vr[pos] < vr || (rq_vr[pos] == vr && rq_tid[pos] <= tid)))
			pos++;
		for (int i = rq_count; i > pos; i--) begin
			rq_vr[i] = rq_vr[i-1];
			rq_tid[i] = rq_tid[i-1];
			rq_nice[i] = rq_nice[i-1];
		end
		rq_vr[pos] = vr;
		rq_tid[pos] = tid;
		rq_nice[pos] = n;
		rq_count++;
		load_sum = load_sum + nice_weight(n);
		return 1;
	endfunction

	task automatic sched_step(input sched_event_t e);
		sched_result_t res;
		logic [63:0] vr, lim, cw, ideal, ran;
		res = '{0, STAT_OK, 0, 0};
		case (e.mode)
			MODE_ADD, MODE_WAKE: begin
				charge_running(e.now);
				if (e.mode == MODE_ADD) begin
					vr = floor_vr;
				end else begin
					lim = (floor_vr > 64'(bonus_reg)) ? floor_vr - 64'(bonus_reg) : 0;
					vr = (e.vr < lim) ? lim : e.vr;
				end
				if (!ready_insert(vr, e.tid, e.nice)) res.stat = STAT_FULL;
				else if (!run_valid || vr < run_vr) res.want = 1;
			end
			MODE_YIELD: begin
				charge_running(e.now);
				if (run_valid) begin
					if (ready_insert(run_vr, run_tid, run_nice)) run_valid = 0;
					else res.stat = STAT_FULL;
				end
			end
			MODE_PICK: begin
				if (rq_count == 0) begin
					res.stat = STAT_EMPTY;
				end else begin
					run_valid = 1;
					run_vr = rq_vr[0];
					run_tid = rq_tid[0];
					run_nice = rq_nice[0];
					load_sum = load_sum - nice_weight(rq_nice[0]);
					rq_count--;
					for (int i = 0; i < rq_count; i++) begin
						rq_vr[i] = rq_vr[i+1];
						rq_tid[i] = rq_tid[i+1];
						rq_nice[i] = rq_nice[i+1];
					end
					run_start = e.now;
					run_last = e.now;
					res.tid = run_tid;
					res.vr = run_vr;
				end
			end
			MODE_TICK: begin
				charge_running(e.now);
				if (run_valid && rq_count > 0) begin
					cw = nice_weight(run_nice);
					ideal = 64'(period_reg) * 64'(rq_count + 1) * cw / (load_sum + cw);
					ran = (e.now > run_start) ? e.now - run_start : 0;
					if (ideal < 64'(min_slice_reg)) ideal = 64'(min_slice_reg);
					if (ran >= ideal) res.want = 1;
				end
			end
			MODE_BLOCK: begin
				charge_running(e.now);
				if (run_valid) begin
					res.tid = run_tid;
					res.vr = run_vr;
					run_valid = 0;
				end
			end
			default: ;
		endcase
		result_q.push_back(res);
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) sched_step(cur);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (event_q.size() > 0) begin
					cur = event_q.pop_front();
					mode <= cur.mode;
					now <= cur.now;
					thread_id <= cur.tid;
					thread_nice <= cur.nice;
					thread_vruntime <= cur.vr;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (long_hold > 0) begin
			long_hold--;
			out_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_left = $urandom_range(20, 300);
				stall_mode = $urandom_range(0, 1);
			end else begin
				stall_left--;
			end
			out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		sched_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report("unexpected transfer", out_thread_id, 0);
			end else begin
				e = result_q.pop_front();
				if (want_resched !== e.want) report("want_resched", want_resched, e.want);
				if (status !== e.stat) report("status", status, e.stat);
				if (out_thread_id !== e.tid) report("out_thread_id", out_thread_id, e.tid);
				if (out_vruntime !== e.vr) report("out_vruntime", out_vruntime, e.vr);
			end
		end
	end

	task automatic push_event(input logic [2:0] m, input logic [63:0] t, input logic [15:0] tid,
			input logic [5:0] n, input logic [63:0] vr);
		sched_event_t e;
		e.mode = m;
		e.now = t;
		e.tid = tid;
		e.nice = n;
		e.vr = vr;
		event_q.push_back(e);
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (event_q.size() != 0 || in_valid || result_q.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			CFG_SLEEP_BONUS: bonus_reg = val;
			CFG_PERIOD: period_reg = val;
			CFG_MIN_SLICE: min_slice_reg = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_events(input int count, input int fill_bias);
		int r;
		logic [2:0] m;
		logic [63:0] t, vr;
		logic [15:0] tid;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20 + fill_bias) m = MODE_ADD;
			else if (r < 38 + fill_bias) m = MODE_WAKE;
			else if (r < 60) m = MODE_PICK;
			else if (r < 78) m = MODE_TICK;
			else if (r < 87) m = MODE_YIELD;
			else if (r < 98) m = MODE_BLOCK;
			else m = 3'($urandom_range(6, 7));
			if ($urandom_range(0, 3) != 0) tnow = tnow + $urandom_range(0, 6000000);
			t = tnow;
			if ($urandom_range(0, 29) == 0) t = tnow - $urandom_range(0, 10000000);
			tid = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
			vr = tnow + $urandom_range(0, 60000000) - 30000000;
			if ($urandom_range(0, 9) == 0) vr = 0;
			push_event(m, t, tid, 6'($urandom), vr);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// idle and empty corner events
		push_event(MODE_PICK, 0, 0, 0, 0);
		push_event(MODE_TICK, 0, 0, 0, 0);
		push_event(MODE_YIELD, 10, 0, 0, 0);
		push_event(MODE_BLOCK, 20, 0, 0, 0);
		push_event(MODE_ADD, 100, 5, -6'sd20, 0);
		push_event(MODE_ADD, 200, 3, 6'sd19, 0);
		push_event(MODE_WAKE, 300, 7, 6'sd31, 0);
		push_event(MODE_WAKE, 400, 16'hFFFF, -6'sd32, 64'd5000);
		push_event(MODE_PICK, 1000, 0, 0, 0);
		push_event(MODE_TICK, 2000, 0, 0, 0);
		push_event(MODE_TICK, 5000000, 0, 0, 0);
		push_event(MODE_ADD, 6000000, 11, 0, 0);
		push_event(MODE_YIELD, 7000000, 0, 0, 0);
		push_event(MODE_PICK, 8000000, 0, 0, 0);
		push_event(MODE_TICK, 100, 0, 0, 0);
		push_event(MODE_BLOCK, 9000000, 0, 0, 0);
		push_event(3'd6, 9100000, 16'hFFFF, -6'sd1, ALL_ONES);
		push_event(3'd7, 9200000, 1, 1, 1);
		push_event(MODE_PICK, 9300000, 0, 0, 0);
		push_event(MODE_WAKE, 40000000, 12, 6'sd10, 0);
		push_event(MODE_TICK, 90000000, 0, 0, 0);
		push_event(MODE_YIELD, 95000000, 0, 0, 0);
		push_event(MODE_BLOCK, 96000000, 0, 0, 0);
		tnow = 100000000;
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_cfg(CFG_SLEEP_BONUS, 0);
					write_cfg(CFG_PERIOD, 1);
					write_cfg(CFG_MIN_SLICE, 0);
				end
				1: begin
					write_cfg(CFG_SLEEP_BONUS, 32'hFFFF_FFFF);
					write_cfg(CFG_PERIOD, 32'hFFFF_FFFF);
					write_cfg(CFG_MIN_SLICE, 32'hFFFF_FFFF);
				end
				2: begin
					write_cfg(CFG_SLEEP_BONUS, $urandom_range(0, 50000000));
					write_cfg(CFG_PERIOD, $urandom_range(1, 8000000));
					write_cfg(CFG_MIN_SLICE, $urandom_range(0, 3000000));
					long_hold = 3000;
				end
				3: begin
					write_cfg(CFG_SLEEP_BONUS, RST_SLEEP_BONUS);
					write_cfg(CFG_PERIOD, RST_PERIOD);
					write_cfg(CFG_MIN_SLICE, RST_MIN_SLICE);
				end
				default: begin
					write_cfg(CFG_SLEEP_BONUS, $urandom);
					write_cfg(CFG_PERIOD, 32'($urandom_range(1, 32'hFFFF_FFFE)));
					write_cfg(CFG_MIN_SLICE, $urandom);
				end
			endcase
			random_events(250, (ph == 1 || ph == 3) ? 12 : 0);
			wait_idle();
		end

		// saturation and full-range values last, since the floor never comes back down
		for (int i = 0; i < 70; i++) push_event(MODE_PICK, tnow, 0, 0, 0);
		push_event(MODE_WAKE, tnow, 16'h8000, 6'sd19, 64'hFFFF_FFFF_FFFF_FF00);
		push_event(MODE_PICK, tnow + 1, 0, 0, 0);
		push_event(MODE_TICK, ALL_ONES, 0, 0, 0);
		push_event(MODE_ADD, ALL_ONES, 16'hAAAA, 6'sd5, 0);
		push_event(MODE_BLOCK, ALL_ONES, 0, 0, 0);
		for (int i = 0; i < 20; i++)
			push_event(3'($urandom_range(0, 5)), {$urandom, $urandom}, 16'($urandom),
				6'($urandom), {$urandom, $urandom});
		wait_idle();

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
hdl/frs_pkg.sv
hdl/frs_ram.sv
hdl/frs_div.sv
hdl/frs_dp.sv
hdl/frs_ctrl.sv
hdl/fair_share_run_queue_unit.sv
tb/sv/fair_share_run_queue_unit_tb.sv
